// File: src/sidc_pkg.sv
package sidc_pkg;

    // Width of the integer taken in and of one ASCII character given out.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    // Ten BCD digits cover every magnitude up to 2^32.
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int DIGCNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Status passed from the binary-to-BCD converter to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

endpackage

// File: src/sidc_bcd_conv.sv
module sidc_bcd_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sidc_pkg::VALUE_W-1:0]  magnitude,
    output sidc_pkg::conv_status_t        status,
    output logic [sidc_pkg::BCD_W-1:0]    bcd
);
    import sidc_pkg::*;

    // Shift-and-add-3: one magnitude bit enters the BCD register per cycle.
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] count_reg, count_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [BCD_W-1:0]    adjusted;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                adjusted[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mag_next   = magnitude;
            bcd_next   = '0;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adjusted[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next   = {mag_reg[VALUE_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (count_reg == BITCNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// File: src/signed_int_to_decimal_ascii_top.sv
// Signed integer to decimal text. Each item on the input channel carries one
// signed 32-bit value; the block answers with its decimal text as a run of
// ASCII characters on the output channel, most significant first, a minus
// sign leading for negative values, leading zeros dropped, zero giving a
// single '0'. The run is 1 to 11 items long and its final item has last set.
// The block handles one value at a time: in_stall is high from acceptance
// until the last character has been loaded into the output register. After
// the accepting edge a value passes through the bit-serial binary-to-BCD
// converter (one magnitude bit per cycle), and then the ten BCD digits are
// captured. Leading zeros are then stripped (one digit per cycle, at most
// nine) until a nonzero digit or the units digit is on top, and control
// moves on to emission. Emission loads the characters into the output
// register, the minus sign first for a negative value, while the output side
// keeps stall low; a stall on the output side holds emission back. A new
// item can be accepted once the last character has been loaded.
// The output register holds the final character while the next value is
// being accepted, so the two sides overlap at the seam between items.
module signed_int_to_decimal_ascii_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sidc_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sidc_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import sidc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [BCD_W-1:0]      digit_reg, digit_next;
    logic [DIGCNT_W-1:0]   remaining_reg, remaining_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  slot_free;
    logic [VALUE_W-1:0]    magnitude;
    logic [BCD_W-1:0]      conv_bcd;
    conv_status_t          conv_stat;
    logic [3:0]            top_digit;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    // The most negative value negates to itself, which read unsigned is the
    // correct magnitude.
    assign magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
    assign top_digit = digit_reg[BCD_W-1 -: 4];

    sidc_bcd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (magnitude),
        .status    (conv_stat),
        .bcd       (conv_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        digit_next     = digit_reg;
        remaining_next = remaining_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[VALUE_W-1];
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_stat.done)
                begin
                    digit_next     = conv_bcd;
                    remaining_next = DIGCNT_W'(DIGITS);
                    state_next     = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros but always keep the units digit.
                if (top_digit == 4'd0 && remaining_reg != DIGCNT_W'(1))
                begin
                    digit_next     = {digit_reg[BCD_W-5:0], 4'd0};
                    remaining_next = remaining_reg - 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next = ASCII_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        char_next      = ASCII_ZERO + {4'd0, top_digit};
                        last_next      = (remaining_reg == DIGCNT_W'(1));
                        digit_next     = {digit_reg[BCD_W-5:0], 4'd0};
                        remaining_next = remaining_reg - 1'b1;
                        if (remaining_reg == DIGCNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            digit_reg     <= '0;
            remaining_reg <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_reg     <= digit_next;
            remaining_reg <= remaining_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // The minus sign is never the final character of a run.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(char_reg == ASCII_MINUS && last_reg))
        else $error("minus sign flagged as last character");

    // A new value is only taken while the converter is free.
    a_accept_conv_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !conv_stat.busy)
        else $error("value accepted while converter busy");

    // The converter finishes only while the control waits for it.
    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> state_reg == S_CONV)
        else $error("conversion finished outside the conversion state");

    // Stripping and emission always have at least one digit left to give.
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT || state_reg == S_SKIP) |-> remaining_reg != '0)
        else $error("digit count ran out before the last character");

endmodule
